// File: rtl/ncof_pkg.sv
// ---------------------------------------------------------------------------
// ncof_pkg
// Shared types and constants for the nearest-centroid outlier flag block.
// ---------------------------------------------------------------------------
`default_nettype none

package ncof_pkg;

  localparam int MAX_CENTROIDS = 8;
  localparam int MAX_DIMS      = 16;
  localparam int CENT_W        = $clog2(MAX_CENTROIDS);
  localparam int COL_W         = $clog2(MAX_DIMS);
  localparam int TAB_DEPTH     = MAX_CENTROIDS * MAX_DIMS;
  localparam int TAB_AW        = $clog2(TAB_DEPTH);
  localparam int VAL_W         = 16;
  localparam int DIFF_W        = VAL_W + 1;
  localparam int PROD_W        = 2 * DIFF_W;
  localparam int SQ_W          = PROD_W - 1;
  localparam int ACC_W         = 38;
  localparam int NC_W          = 4;
  localparam int ND_W          = 5;
  localparam int CFG_IDX_W     = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTROIDS = 2'd0,
    CFG_DIMS      = 2'd1,
    CFG_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_CENTROID = 1'b0,
    CMD_POINT    = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                    cmd;
    logic [2:0]              centroid_index;
    logic [3:0]              coord_index;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             is_outlier;
    logic [2:0]       nearest_centroid;
    logic [ACC_W-1:0] min_distance_squared;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/ncof_ram.sv
// ---------------------------------------------------------------------------
// ncof_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module ncof_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/nearest_centroid_outlier_flag.sv
// ---------------------------------------------------------------------------
// nearest_centroid_outlier_flag
// Accumulates squared distances of a streamed point to a table of centroids
// and reports the nearest centroid and whether it lies beyond a threshold.
// ---------------------------------------------------------------------------
// A point coordinate holds in_ready low while one accumulator read-modify-write
// is issued per centroid, nc being the effective centroid count (1 to 8), and
// then while the pipeline drains. A last coordinate also passes through a
// result state that loads the output register and waits there while the
// previous result is still held. A centroid write leaves in_ready high.
// Reset restores the registers to 8, 16 and 0 and zeroes the accumulators.
`default_nettype none

module nearest_centroid_outlier_flag (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire ncof_pkg::in_t                       in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output ncof_pkg::out_t                           out_data,
  input  wire logic                                cfg_we,
  input  wire logic [ncof_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ncof_pkg::ACC_W-1:0]          cfg_data
);

  // Configuration registers.
  logic [ncof_pkg::NC_W-1:0]  centroids_in_use;
  logic [ncof_pkg::ND_W-1:0]  dims_in_use;
  logic [ncof_pkg::ACC_W-1:0] threshold_squared;

  always_ff @(posedge clk) begin
    if (rst) begin
      centroids_in_use  <= ncof_pkg::NC_W'(ncof_pkg::MAX_CENTROIDS);
      dims_in_use       <= ncof_pkg::ND_W'(ncof_pkg::MAX_DIMS);
      threshold_squared <= '0;
    end else if (cfg_we) begin
      unique case (ncof_pkg::cfg_reg_t'(cfg_index))
        ncof_pkg::CFG_CENTROIDS: centroids_in_use  <= cfg_data[ncof_pkg::NC_W-1:0];
        ncof_pkg::CFG_DIMS:      dims_in_use       <= cfg_data[ncof_pkg::ND_W-1:0];
        ncof_pkg::CFG_THRESHOLD: threshold_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective last centroid index and last coordinate, with clamping.
  logic [ncof_pkg::CENT_W-1:0] nc_last;
  logic [ncof_pkg::COL_W-1:0]  nd_last;

  always_comb begin
    if (centroids_in_use == '0) begin
      nc_last = '0;
    end else if (centroids_in_use > ncof_pkg::NC_W'(ncof_pkg::MAX_CENTROIDS)) begin
      nc_last = ncof_pkg::CENT_W'(ncof_pkg::MAX_CENTROIDS - 1);
    end else begin
      nc_last = ncof_pkg::CENT_W'(centroids_in_use - 1'b1);
    end
    if (dims_in_use == '0) begin
      nd_last = '0;
    end else if (dims_in_use > ncof_pkg::ND_W'(ncof_pkg::MAX_DIMS)) begin
      nd_last = ncof_pkg::COL_W'(ncof_pkg::MAX_DIMS - 1);
    end else begin
      nd_last = ncof_pkg::COL_W'(dims_in_use - 1'b1);
    end
  end

  // Control.
  ncof_pkg::state_t state, state_next;
  logic             issue;
  logic             load_out;
  logic             out_free;
  logic             accept;
  logic             point_go;
  logic             tab_we;

  logic [ncof_pkg::CENT_W-1:0] k;
  logic                        p1_valid, p2_valid;
  logic [ncof_pkg::CENT_W-1:0] k1, k2;

  logic [ncof_pkg::COL_W-1:0]         item_col;
  logic signed [ncof_pkg::VAL_W-1:0]  item_value;
  logic                               item_last;

  assign out_free = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign tab_we   = accept && (in_data.cmd == ncof_pkg::CMD_CENTROID);
  // A point coordinate beyond the last dimension is taken and dropped.
  assign point_go = accept && (in_data.cmd == ncof_pkg::CMD_POINT)
                    && (in_data.coord_index <= nd_last);

  always_comb begin
    state_next = state;
    unique case (state)
      ncof_pkg::S_IDLE:   if (point_go) state_next = ncof_pkg::S_RUN;
      ncof_pkg::S_RUN:    if (k == nc_last) state_next = ncof_pkg::S_DRAIN;
      ncof_pkg::S_DRAIN: begin
        if (!p1_valid && !p2_valid) begin
          state_next = item_last ? ncof_pkg::S_RESULT : ncof_pkg::S_IDLE;
        end
      end
      ncof_pkg::S_RESULT: if (out_free) state_next = ncof_pkg::S_IDLE;
      default:            state_next = ncof_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ncof_pkg::S_IDLE:   in_ready = 1'b1;
      ncof_pkg::S_RUN:    issue    = 1'b1;
      ncof_pkg::S_DRAIN:  ;
      ncof_pkg::S_RESULT: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ncof_pkg::S_IDLE;
      k        <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      state    <= state_next;
      k        <= issue ? k + 1'b1 : '0;
      p1_valid <= issue;
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (point_go) begin
      item_col   <= in_data.coord_index;
      item_value <= in_data.value;
      item_last  <= (in_data.coord_index == nd_last);
    end
    k1 <= k;
    k2 <= k1;
  end

  // Centroid table memory, row-major: {centroid, coordinate}.
  logic [ncof_pkg::VAL_W-1:0] tab_rdata;

  ncof_ram #(
    .WIDTH (ncof_pkg::VAL_W),
    .DEPTH (ncof_pkg::TAB_DEPTH)
  ) u_centroid_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr ({in_data.centroid_index, in_data.coord_index}),
    .wdata (in_data.value),
    .raddr ({k, item_col}),
    .rdata (tab_rdata)
  );

  // Accumulator memory. Each entry is touched once per coordinate and the
  // next coordinate waits for the drain, so no two accesses overlap.
  logic [ncof_pkg::ACC_W-1:0] acc_rdata;
  logic [ncof_pkg::ACC_W-1:0] acc_new;

  ncof_ram #(
    .WIDTH (ncof_pkg::ACC_W),
    .DEPTH (ncof_pkg::MAX_CENTROIDS)
  ) u_acc_ram (
    .clk   (clk),
    .we    (p2_valid),
    .waddr (k2),
    .wdata (acc_new),
    .raddr (k),
    .rdata (acc_rdata)
  );

  // An entry without its valid bit reads as zero; the first coordinate of a
  // point drops all valid bits, which clears every accumulator at once.
  logic [ncof_pkg::MAX_CENTROIDS-1:0] acc_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= '0;
    end else if (point_go && (in_data.coord_index == '0)) begin
      acc_valid <= '0;
    end else if (p2_valid) begin
      acc_valid[k2] <= 1'b1;
    end
  end

  // Stage 1: difference and square.
  logic signed [ncof_pkg::VAL_W-1:0]  cent_val;
  logic signed [ncof_pkg::DIFF_W-1:0] diff;
  logic signed [ncof_pkg::PROD_W-1:0] prod;
  logic [ncof_pkg::SQ_W-1:0]          sq;
  logic [ncof_pkg::ACC_W-1:0]         acc_old;

  assign cent_val = tab_rdata;
  assign diff     = ncof_pkg::DIFF_W'(item_value) - ncof_pkg::DIFF_W'(cent_val);
  assign prod     = diff * diff;

  always_ff @(posedge clk) begin
    sq      <= prod[ncof_pkg::SQ_W-1:0];
    acc_old <= acc_valid[k1] ? acc_rdata : '0;
  end

  // Stage 2: saturating add, write back, running minimum.
  logic [ncof_pkg::ACC_W:0]    sum;
  logic [ncof_pkg::ACC_W-1:0]  best_d;
  logic [ncof_pkg::CENT_W-1:0] best_k;

  assign sum     = {1'b0, acc_old} + (ncof_pkg::ACC_W + 1)'(sq);
  assign acc_new = sum[ncof_pkg::ACC_W] ? ncof_pkg::ACC_MAX : sum[ncof_pkg::ACC_W-1:0];

  // Centroids arrive in ascending order, so a strict compare keeps the
  // lowest index on ties.
  always_ff @(posedge clk) begin
    if (p2_valid && ((k2 == '0) || (acc_new < best_d))) begin
      best_d <= acc_new;
      best_k <= k2;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load_out || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.is_outlier           <= (best_d > threshold_squared);
      out_data.nearest_centroid     <= 3'(best_k);
      out_data.min_distance_squared <= best_d;
    end
  end

  // Assertions.
  a_pipe_in_work: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> (state == ncof_pkg::S_RUN || state == ncof_pkg::S_DRAIN))
    else $error("accumulator write outside a point pass");

  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    p2_valid |-> (k2 <= nc_last))
    else $error("accumulator write beyond centroids in use");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (p1_valid && p2_valid) |-> (k1 == k2 + 1'b1))
    else $error("centroid passes out of order");

  a_result_last: assert property (@(posedge clk) disable iff (rst)
    (state == ncof_pkg::S_RESULT) |-> item_last)
    else $error("result for a coordinate that does not end a point");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest-centroid outlier flag. A short scripted
// sequence covers ties, the strict threshold compare, ignored coordinates and
// clamped counts. Random centroid updates and points follow under several
// register settings and handshake stall patterns. Each result is compared with
// a distance predictor alongside the block, or with the script's expectation.
// ---------------------------------------------------------------------------

module tb_top;
  import ncof_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 85;
  localparam int HOLD_CYCLES   = 400;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    cfg_reg_t         idx;
    logic [ACC_W-1:0] data;
    in_t              item;
    bit               known;
    out_t             want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ACC_W-1:0]     cfg_data = '0;

  // Predictor state.
  logic signed [VAL_W-1:0] cent_mem [TAB_DEPTH];
  logic [ACC_W-1:0]        dist_sum [MAX_CENTROIDS];
  logic [NC_W-1:0]         cfg_ncent;
  logic [ND_W-1:0]         cfg_ndims;
  logic [ACC_W-1:0]        cfg_thresh;

  out_t  nearest_q [$];
  step_t script [$];
  out_t  want_r;
  int    mismatches = 0;
  int    items_sent = 0;
  int    send_idle_pct = 17;
  int    recv_idle_pct = 83;
  int    hold_left = 0;
  int    taken = 0;
  int    quiet = 0;

  nearest_centroid_outlier_flag dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int clip_count(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic in_t mk(cmd_t c, int row, int col, logic [VAL_W-1:0] v);
    in_t it;
    it.cmd            = c;
    it.centroid_index = 3'(row);
    it.coord_index    = 4'(col);
    it.value          = v;
    return it;
  endfunction

  // Applies one accepted item and reports the nearest centroid when it ends a point.
  function automatic void track_distance(input in_t it, output bit has_res, output out_t res);
    int     nc;
    int     nd;
    int     col;
    int     best;
    longint diff;
    logic [ACC_W:0] total;
    has_res = 1'b0;
    res     = '0;
    nc  = clip_count(cfg_ncent, MAX_CENTROIDS);
    nd  = clip_count(cfg_ndims, MAX_DIMS);
    col = it.coord_index;
    if (it.cmd == CMD_CENTROID) begin
      cent_mem[it.centroid_index * MAX_DIMS + col] = it.value;
    end else if (col < nd) begin
      if (col == 0) begin
        foreach (dist_sum[k]) dist_sum[k] = '0;
      end
      for (int k = 0; k < nc; k++) begin
        diff  = longint'($signed(it.value)) - longint'(cent_mem[k * MAX_DIMS + col]);
        total = {1'b0, dist_sum[k]} + (ACC_W+1)'(diff * diff);
        dist_sum[k] = total[ACC_W] ? ACC_MAX : total[ACC_W-1:0];
      end
      if (col == nd - 1) begin
        best = 0;
        for (int k = 1; k < nc; k++) begin
          if (dist_sum[k] < dist_sum[best]) best = k;
        end
        has_res                  = 1'b1;
        res.is_outlier           = dist_sum[best] > cfg_thresh;
        res.nearest_centroid     = 3'(best);
        res.min_distance_squared = dist_sum[best];
      end
    end
  endfunction

  function automatic void add_reg(cfg_reg_t r, logic [ACC_W-1:0] v);
    step_t s;
    s.kind  = ROW_REG;
    s.idx   = r;
    s.data  = v;
    s.item  = '0;
    s.known = 1'b0;
    s.want  = '0;
    script.push_back(s);
  endfunction

  function automatic void add_item(cmd_t c, int row, int col, int val, bit known = 1'b0,
                                   bit outl = 1'b0, int near = 0, longint d_sq = 0);
    step_t s;
    s.kind  = ROW_ITEM;
    s.idx   = CFG_CENTROIDS;
    s.data  = '0;
    s.item  = mk(c, row, col, 16'(val));
    s.known = known;
    s.want.is_outlier           = outl;
    s.want.nearest_centroid     = 3'(near);
    s.want.min_distance_squared = ACC_W'(d_sq);
    script.push_back(s);
  endfunction

  function automatic void check_field(string name, logic [ACC_W-1:0] e, logic [ACC_W-1:0] a);
    if (e !== a) begin
      if (mismatches < 10) $display("mismatch on %s: expected %0d, got %0d", name, e, a);
      mismatches++;
    end
  endfunction

  // Lets everything in flight drain so that a register write finds the block idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t r, input logic [ACC_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (r)
      CFG_CENTROIDS: cfg_ncent = v[NC_W-1:0];
      CFG_DIMS:      cfg_ndims = v[ND_W-1:0];
      CFG_THRESHOLD: cfg_thresh = v;
      default: ;
    endcase
  endtask

  task automatic offer(input in_t it, input bit known = 1'b0, input out_t want = '0);
    bit   has_res;
    out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    track_distance(it, has_res, res);
    if (has_res) nearest_q.push_back(known ? want : res);
  endtask

  // Receiver: random stalls, plus two long hold-offs that back the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        taken++;
        if (taken == 40 || taken == 200) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (nearest_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("result with nothing pending: outlier %0d nearest %0d d2 %0d",
                   out_data.is_outlier, out_data.nearest_centroid,
                   out_data.min_distance_squared);
        end
        mismatches++;
      end else begin
        want_r = nearest_q.pop_front();
        check_field("is_outlier", want_r.is_outlier, out_data.is_outlier);
        check_field("nearest_centroid", want_r.nearest_centroid, out_data.nearest_centroid);
        check_field("min_distance_squared", want_r.min_distance_squared,
                    out_data.min_distance_squared);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", quiet);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int nc;
    int nd;
    int first;
    int draw;
    int r;
    logic [NC_W-1:0]  c_set;
    logic [ND_W-1:0]  d_set;
    logic [ACC_W-1:0] thr;
    logic [VAL_W-1:0] v;

    cfg_ncent  = 4'd8;
    cfg_ndims  = 5'd16;
    cfg_thresh = '0;
    foreach (dist_sum[k]) dist_sum[k] = '0;

    // Rows 0 and 1 are the only centroids read until the whole table is loaded.
    add_reg(CFG_CENTROIDS, 2);
    add_reg(CFG_DIMS, 2);
    add_reg(CFG_THRESHOLD, 0);
    add_item(CMD_CENTROID, 0, 0, 256);
    add_item(CMD_CENTROID, 0, 1, 0);
    add_item(CMD_CENTROID, 1, 0, -32768);
    add_item(CMD_CENTROID, 1, 1, 32767);
    add_item(CMD_CENTROID, 7, 15, 23130);
    add_item(CMD_POINT, 5, 0, 256);
    add_item(CMD_POINT, 2, 1, 0, 1'b1, 1'b0, 0, 0);
    add_item(CMD_POINT, 7, 0, 32767);
    add_item(CMD_POINT, 0, 1, -32768);
    add_item(CMD_POINT, 3, 15, 4660);
    add_item(CMD_CENTROID, 1, 0, 768);
    add_item(CMD_CENTROID, 1, 1, 0);
    add_item(CMD_POINT, 0, 0, 512);
    add_item(CMD_POINT, 0, 0, 512);
    add_item(CMD_POINT, 0, 1, 0, 1'b1, 1'b1, 0, 65536);
    add_reg(CFG_THRESHOLD, 65536);
    add_item(CMD_POINT, 0, 0, 512);
    add_item(CMD_POINT, 0, 1, 0, 1'b1, 1'b0, 0, 65536);
    add_reg(CFG_THRESHOLD, 65535);
    add_item(CMD_POINT, 0, 0, 512);
    add_item(CMD_POINT, 0, 1, 0, 1'b1, 1'b1, 0, 65536);
    add_reg(CFG_DIMS, 0);
    add_reg(CFG_CENTROIDS, 0);
    add_item(CMD_POINT, 4, 0, 256, 1'b1, 1'b0, 0, 0);
    add_item(CMD_POINT, 4, 1, 32767);
    add_item(CMD_POINT, 6, 0, -32768);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        set_reg(script[i].idx, script[i].data);
      end else begin
        offer(script[i].item, script[i].known, script[i].want);
      end
    end

    for (int k = 0; k < TAB_DEPTH; k++) begin
      offer(mk(CMD_CENTROID, k / MAX_DIMS, k % MAX_DIMS, 16'($urandom)));
    end

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 17 : (m == 1) ? 83 : 0;
      recv_idle_pct = (m == 0) ? 83 : (m == 1) ? 17 : 0;
      for (int s = 0; s < 6; s++) begin
        case (s)
          0: begin c_set = 8; d_set = 16; end
          1: begin c_set = 1; d_set = 1; end
          2: begin c_set = 0; d_set = 0; end
          3: begin c_set = 15; d_set = 31; end
          4: begin
            c_set = NC_W'($urandom_range(8, 1));
            d_set = ND_W'($urandom_range(16, 1));
          end
          default: begin c_set = 8; d_set = 3; end
        endcase
        nc  = clip_count(c_set, MAX_CENTROIDS);
        nd  = clip_count(d_set, MAX_DIMS);
        thr = (s == 1) ? '0 : (s == 5) ? ACC_MAX : (ACC_W'(nd) << $urandom_range(32, 12));
        set_reg(CFG_CENTROIDS, ACC_W'(c_set));
        set_reg(CFG_DIMS, ACC_W'(d_set));
        set_reg(CFG_THRESHOLD, thr);
        first = items_sent;

        if (s == 5) begin
          // Seventy repeats of the largest square push every sum past the 38-bit limit.
          for (int k = 0; k < MAX_CENTROIDS; k++) offer(mk(CMD_CENTROID, k, 1, 16'h8000));
          offer(mk(CMD_POINT, 0, 0, 16'h7fff));
          repeat (70) offer(mk(CMD_POINT, 0, 1, 16'h7fff));
          for (int c = 2; c < nd; c++) offer(mk(CMD_POINT, 0, c, 16'h7fff));
        end

        while (items_sent - first < PHASE_ITEMS) begin
          draw = $urandom_range(99);
          if (draw < 60) begin
            r = $urandom_range(nc - 1);
            for (int c = 0; c < nd; c++) begin
              if ($urandom_range(9) == 0) begin
                offer(mk(CMD_CENTROID, $urandom_range(7), $urandom_range(15), 16'($urandom)));
              end
              case ($urandom_range(9))
                0:       v = $urandom_range(1) ? 16'h7fff : 16'h8000;
                1, 2, 3: v = 16'($urandom);
                default: v = cent_mem[r * MAX_DIMS + c] + 16'($urandom_range(512)) - 16'd256;
              endcase
              offer(mk(CMD_POINT, $urandom_range(7), c, v));
            end
          end else if (draw < 72) begin
            // Coordinates in any order, with gaps, repeats and positions past the end.
            repeat ($urandom_range(6, 1)) begin
              offer(mk(CMD_POINT, $urandom_range(7), $urandom_range(15), 16'($urandom)));
            end
          end else if (draw < 88) begin
            repeat ($urandom_range(4, 1)) begin
              offer(mk(CMD_CENTROID, $urandom_range(7), $urandom_range(15), 16'($urandom)));
            end
          end else begin
            offer(mk(CMD_POINT, $urandom_range(7), $urandom_range(15), 16'($urandom)));
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ncof_pkg.sv
rtl/ncof_ram.sv
rtl/nearest_centroid_outlier_flag.sv
sim/tb_top.sv
